// File: rtl/uje_pkg.sv
package uje_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [2:0] TAIL_NONE = 3'd0;
	localparam logic [2:0] TAIL_RAW  = 3'd1;
	localparam logic [2:0] TAIL_ESC  = 3'd2;
	localparam logic [2:0] TAIL_UNI  = 3'd3;
	localparam logic [2:0] TAIL_QM   = 3'd4;

	localparam logic [7:0] LEAD_2B_MIN = 8'hC2;
	localparam logic [7:0] LEAD_3B_MIN = 8'hE0;
	localparam logic [7:0] LEAD_4B_MIN = 8'hF0;
	localparam logic [7:0] LEAD_BAD    = 8'hF5;
	localparam logic [7:0] CONT_MASK   = 8'hC0;
	localparam logic [7:0] CONT_CODE   = 8'h80;
	localparam logic [7:0] LEAD_E0     = 8'hE0;
	localparam logic [7:0] E0_MIN      = 8'hA0;
	localparam logic [7:0] LEAD_ED     = 8'hED;
	localparam logic [7:0] ED_MAX      = 8'h9F;
	localparam logic [7:0] LEAD_F0     = 8'hF0;
	localparam logic [7:0] F0_MIN      = 8'h90;
	localparam logic [7:0] LEAD_F4     = 8'hF4;
	localparam logic [7:0] F4_MAX      = 8'h8F;
	localparam logic [7:0] CTRL_LIMIT  = 8'h20;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_ZERO   = 8'h30;

	typedef struct packed {
		logic [2:0][7:0] held;
		logic [1:0]      n_pre;
		logic            pre_qm;
		logic [2:0]      tail;
		logic [7:0]      tail_byte;
		logic            last;
		logic            ok;
	} cmd_t;

	function automatic logic [2:0] seq_len(input logic [7:0] lead);
		logic [2:0] len;
		if (lead < CONT_CODE)        len = 3'd1;
		else if (lead < LEAD_2B_MIN) len = 3'd0;
		else if (lead < LEAD_3B_MIN) len = 3'd2;
		else if (lead < LEAD_4B_MIN) len = 3'd3;
		else if (lead < LEAD_BAD)    len = 3'd4;
		else                         len = 3'd0;
		return len;
	endfunction

	// character after the backslash, zero if the byte is not a short escape
	function automatic logic [7:0] esc_char(input logic [7:0] b);
		logic [7:0] c;
		unique case (b)
			8'h22:   c = 8'h22;
			8'h5C:   c = 8'h5C;
			8'h0A:   c = 8'h6E;
			8'h0D:   c = 8'h72;
			8'h09:   c = 8'h74;
			8'h08:   c = 8'h62;
			8'h0C:   c = 8'h66;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		logic [7:0] c;
		if (v < 4'd10) c = {4'h0, v} + 8'h30;
		else           c = {4'h0, v} + 8'h57;
		return c;
	endfunction

	function automatic logic [3:0] tail_len(input logic [2:0] tail);
		logic [3:0] n;
		unique case (tail)
			TAIL_RAW: n = 4'd1;
			TAIL_QM:  n = 4'd1;
			TAIL_ESC: n = 4'd2;
			TAIL_UNI: n = 4'd6;
			default:  n = 4'd0;
		endcase
		return n;
	endfunction

endpackage

// File: rtl/uje_front.sv
module uje_front import uje_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] in_byte,
	input  logic       text_last,
	output logic       push,
	output cmd_t       cmd
);

	logic [7:0] held_q [3];
	logic [1:0] held_count_q;
	logic [2:0] exp_len_q;
	logic       text_ok_q;

	logic [2:0] f_tail;
	logic [7:0] f_char;
	logic [7:0] esc;
	logic       f_bad;
	logic       f_start;
	logic [2:0] f_len;

	logic       seq_ok;
	logic       complete;
	logic       bad;
	logic       start;
	logic       extend;
	logic       ok_after;

	always_comb begin
		f_tail  = TAIL_NONE;
		f_char  = in_byte;
		f_bad   = 1'b0;
		f_start = 1'b0;
		f_len   = seq_len(in_byte);
		esc     = esc_char(in_byte);
		if (!in_byte[7]) begin
			if (esc != 8'h00) begin
				f_tail = TAIL_ESC;
				f_char = esc;
			end else if (in_byte < CTRL_LIMIT) begin
				f_tail = TAIL_UNI;
			end else begin
				f_tail = TAIL_RAW;
			end
		end else if (f_len == 3'd0 || text_last) begin
			f_tail = TAIL_QM;
			f_bad  = 1'b1;
		end else begin
			f_start = 1'b1;
		end
	end

	always_comb begin
		seq_ok = (in_byte & CONT_MASK) == CONT_CODE;
		if (held_count_q == 2'd1) begin
			if (held_q[0] == LEAD_E0 && in_byte < E0_MIN) seq_ok = 1'b0;
			if (held_q[0] == LEAD_ED && in_byte > ED_MAX) seq_ok = 1'b0;
			if (held_q[0] == LEAD_F0 && in_byte < F0_MIN) seq_ok = 1'b0;
			if (held_q[0] == LEAD_F4 && in_byte > F4_MAX) seq_ok = 1'b0;
		end
		complete = ({1'b0, held_count_q} + 3'd1) >= exp_len_q;

		cmd.held      = {held_q[2], held_q[1], held_q[0]};
		cmd.n_pre     = 2'd0;
		cmd.pre_qm    = 1'b0;
		cmd.tail      = TAIL_NONE;
		cmd.tail_byte = in_byte;
		cmd.last      = text_last;
		bad           = 1'b0;
		start         = 1'b0;
		extend        = 1'b0;

		if (held_count_q == 2'd0) begin
			cmd.tail      = f_tail;
			cmd.tail_byte = f_char;
			bad           = f_bad;
			start         = f_start;
		end else if (seq_ok) begin
			if (complete) begin
				cmd.n_pre = held_count_q;
				cmd.tail  = TAIL_RAW;
			end else if (text_last) begin
				cmd.n_pre  = held_count_q;
				cmd.pre_qm = 1'b1;
				cmd.tail   = TAIL_QM;
				bad        = 1'b1;
			end else begin
				extend = 1'b1;
			end
		end else begin
			cmd.n_pre     = held_count_q;
			cmd.pre_qm    = 1'b1;
			cmd.tail      = f_tail;
			cmd.tail_byte = f_char;
			bad           = 1'b1;
			start         = f_start;
		end

		ok_after = text_ok_q & ~bad;
		cmd.ok   = ok_after;
		push     = fire && (cmd.n_pre != 2'd0 || cmd.tail != TAIL_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= 2'd0;
			exp_len_q    <= 3'd0;
			text_ok_q    <= 1'b1;
		end else if (fire) begin
			if (text_last) begin
				held_count_q <= 2'd0;
				exp_len_q    <= 3'd0;
				text_ok_q    <= 1'b1;
			end else begin
				text_ok_q <= ok_after;
				if (start) begin
					held_count_q <= 2'd1;
					exp_len_q    <= f_len;
				end else if (extend) begin
					held_count_q <= held_count_q + 2'd1;
				end else begin
					held_count_q <= 2'd0;
					exp_len_q    <= 3'd0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && !text_last) begin
			if (start)       held_q[0]            <= in_byte;
			else if (extend) held_q[held_count_q] <= in_byte;
		end
	end

	a_hold_len: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q != 2'd0 |-> exp_len_q > {1'b0, held_count_q})
		else $error("held count not below sequence length");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && text_last |=> held_count_q == 2'd0 && text_ok_q)
		else $error("hold state not cleared after end of text");

endmodule

// File: rtl/uje_queue.sv
module uje_queue import uje_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] count_q;

	assign full  = count_q == CW'(DEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

endmodule

// File: rtl/uje_back.sv
module uje_back import uje_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  cmd_t       head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       text_done,
	output logic       text_valid
);

	logic [3:0] pos_q;
	logic [3:0] total;
	logic [3:0] t;
	logic [7:0] nxt_byte;
	logic       is_last;
	logic       load;

	logic       valid_q;
	logic [7:0] byte_q;
	logic       run_last_q;
	logic       done_q;
	logic       ok_q;

	always_comb begin
		total    = {2'b00, head.n_pre} + tail_len(head.tail);
		t        = pos_q - {2'b00, head.n_pre};
		is_last  = pos_q == total - 4'd1;
		nxt_byte = CH_QMARK;
		if (pos_q < {2'b00, head.n_pre}) begin
			nxt_byte = head.pre_qm ? CH_QMARK : head.held[pos_q[1:0]];
		end else begin
			unique case (head.tail)
				TAIL_RAW: nxt_byte = head.tail_byte;
				TAIL_ESC: nxt_byte = (t == 4'd0) ? CH_BSLASH : head.tail_byte;
				TAIL_UNI: begin
					unique case (t)
						4'd0:    nxt_byte = CH_BSLASH;
						4'd1:    nxt_byte = CH_U;
						4'd2:    nxt_byte = CH_ZERO;
						4'd3:    nxt_byte = CH_ZERO;
						4'd4:    nxt_byte = hex_digit(head.tail_byte[7:4]);
						default: nxt_byte = hex_digit(head.tail_byte[3:0]);
					endcase
				end
				default: nxt_byte = CH_QMARK;
			endcase
		end
		load = head_valid && (!valid_q || out_ready);
		pop  = load && is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 4'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) pos_q <= is_last ? 4'd0 : pos_q + 4'd1;
			if (load)           valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q     <= nxt_byte;
			run_last_q <= is_last;
			done_q     <= is_last && head.last;
			ok_q       <= is_last && head.last && head.ok;
		end
	end

	assign out_valid  = valid_q;
	assign out_byte   = byte_q;
	assign run_last   = run_last_q;
	assign text_done  = done_q;
	assign text_valid = ok_q;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> pos_q < total)
		else $error("output position beyond command length");

	a_valid_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && text_valid |-> text_done && run_last)
		else $error("text status without end of text");

endmodule

// File: rtl/utf8_validating_json_escaper_core.sv
// Each output byte passes through the command queue and the back-end output register.
// Throughput: one input item per cycle, and one output byte per cycle while the
// output is ready; a k-byte item holds the output side until it is sent; the input
// stalls only when the front-to-back command queue (QDEPTH entries) is full.
// Reset (arst_n low, asynchronous): no bytes held, text status valid, queue empty.
module utf8_validating_json_escaper_core import uje_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
	input  logic       s_axis_tlast,  // text_last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic       m_axis_tlast,  // run_last
	output logic [1:0] m_axis_tuser   // [0] text_done, [1] text_valid
);

	logic fire;
	logic push;
	logic full;
	logic empty;
	logic pop;
	cmd_t cmd;
	cmd_t head;

	assign s_axis_tready = !full;
	assign fire          = s_axis_tvalid && s_axis_tready;

	uje_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.in_byte   (s_axis_tdata),
		.text_last (s_axis_tlast),
		.push      (push),
		.cmd       (cmd)
	);

	uje_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cmd),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.head      (head)
	);

	uje_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_byte   (m_axis_tdata),
		.run_last   (m_axis_tlast),
		.text_done  (m_axis_tuser[0]),
		.text_valid (m_axis_tuser[1])
	);

endmodule
